// File: hdl/chr_pkg.sv
// Shared types, codes and constants for the replica ring.
// No dependencies; used by every module of the block.
`default_nettype none
package chr_pkg;

    localparam int PosW         = 9;
    localparam int AddrW        = 48;
    localparam int CountOutW    = 5;
    localparam int DefMaxNodes  = 16;
    localparam int Replicas     = 3;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [PosW-1:0]  key_position;
        logic [AddrW-1:0] node_address;
        logic [PosW-1:0]  node_position;
    } t_in_item;

    typedef struct packed {
        logic                 replicas_valid;
        logic [AddrW-1:0]     primary_address;
        logic [AddrW-1:0]     secondary_address;
        logic [AddrW-1:0]     tertiary_address;
        logic [1:0]           status;
        logic [CountOutW-1:0] member_count;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       op;
        logic [PosW-1:0]  pos;
        logic [AddrW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [PosW-1:0]  pos;
        logic [AddrW-1:0] addr;
    } t_entry;

endpackage
`default_nettype wire

// File: hdl/chr_front.sv
// Front end: accepts requests, classifies them into commands, queues them.
// Depends on chr_pkg.
`default_nettype none
module chr_front
    import chr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push, pop;

    always_comb begin
        n_cmd.addr = i_item.node_address;
        case (i_item.mode)
            MODE_LOOKUP: begin
                n_cmd.op  = OP_LOOKUP;
                n_cmd.pos = i_item.key_position;
            end
            MODE_ADD: begin
                n_cmd.op  = OP_ADD;
                n_cmd.pos = i_item.node_position;
            end
            MODE_REMOVE: begin
                n_cmd.op  = OP_REMOVE;
                n_cmd.pos = i_item.node_position;
            end
            default: begin
                n_cmd.op  = OP_NOP;
                n_cmd.pos = i_item.node_position;
            end
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// File: hdl/chr_engine.sv
// Back end: sorted ring table in a memory, walked by a sequencer.
// Depends on chr_pkg; fed by chr_front.
`default_nettype none
module chr_engine
    import chr_pkg::*;
#(
    parameter int MAX_NODES = DefMaxNodes
)
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    output logic       o_cmd_ready,
    input  wire t_cmd  i_cmd,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_out_item  o_item
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_NODES);
    localparam logic [CW-1:0] CntRep = CW'(Replicas);
    localparam logic [CW-1:0] One    = CW'(1);
    localparam logic [CW-1:0] Two    = CW'(2);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_SC_RD  = 4'd2;
    localparam logic [3:0] S_SC_CK  = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_SH_RD  = 4'd5;
    localparam logic [3:0] S_SH_WR  = 4'd6;
    localparam logic [3:0] S_INS    = 4'd7;
    localparam logic [3:0] S_LK_RD  = 4'd8;
    localparam logic [3:0] S_LK_CK  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    t_entry           r_mem [MAX_NODES];
    t_entry           r_rdata;
    logic [3:0]       r_state;
    t_cmd             r_cmd;
    logic [CW-1:0]    r_n, r_i, r_at;
    logic [1:0]       r_k;
    logic             r_hit;
    logic             r_rv;
    logic [AddrW-1:0] r_pri, r_sec, r_ter;
    logic [1:0]       r_status;
    logic             r_ovalid;
    t_out_item        r_out;

    logic [CW-1:0]    raddr;
    logic             wr_en;
    logic [CW-1:0]    waddr;
    t_entry           wdata;
    logic             load;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign load        = (r_state == S_DONE) && (!r_ovalid || i_ready);
    assign o_valid     = r_ovalid;
    assign o_item      = r_out;

    always_comb begin
        raddr = r_i;
        if (r_state == S_SH_RD) begin
            raddr = (r_cmd.op == OP_ADD) ? r_i - One : r_i + One;
        end
        wr_en = 1'b0;
        waddr = r_i;
        wdata = r_rdata;
        if (r_state == S_SH_WR) begin
            wr_en = 1'b1;
        end else if (r_state == S_INS) begin
            wr_en      = 1'b1;
            waddr      = r_at;
            wdata.pos  = r_cmd.pos;
            wdata.addr = r_cmd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr[AW-1:0]] <= wdata;
        end
        r_rdata <= r_mem[raddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.replicas_valid    <= r_rv;
            r_out.primary_address   <= r_pri;
            r_out.secondary_address <= r_sec;
            r_out.tertiary_address  <= r_ter;
            r_out.status            <= r_status;
            r_out.member_count      <= CountOutW'(r_n);
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_rv     <= 1'b0;
                    r_pri    <= '0;
                    r_sec    <= '0;
                    r_ter    <= '0;
                    r_status <= ST_OK;
                    r_i      <= '0;
                    r_at     <= '0;
                    r_k      <= 2'd0;
                    r_hit    <= 1'b0;
                    case (r_cmd.op)
                        OP_LOOKUP: r_state <= (r_n < CntRep) ? S_DONE : S_SC_RD;
                        OP_ADD, OP_REMOVE: r_state <= (r_n == '0) ? S_DECIDE : S_SC_RD;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SC_RD: begin
                    r_state <= S_SC_CK;
                end
                S_SC_CK: begin
                    case (r_cmd.op)
                        OP_LOOKUP: begin
                            if (r_cmd.pos <= r_rdata.pos) begin
                                r_state <= S_LK_RD;
                            end else if (r_i + One == r_n) begin
                                r_i     <= '0;
                                r_state <= S_LK_RD;
                            end else begin
                                r_i     <= r_i + One;
                                r_state <= S_SC_RD;
                            end
                        end
                        OP_ADD: begin
                            if (r_rdata.addr == r_cmd.addr) begin
                                r_hit <= 1'b1;
                            end
                            if (r_rdata.pos <= r_cmd.pos) begin
                                r_at <= r_i + One;
                            end
                            if (r_i + One == r_n) begin
                                r_state <= S_DECIDE;
                            end else begin
                                r_i     <= r_i + One;
                                r_state <= S_SC_RD;
                            end
                        end
                        default: begin
                            if (r_rdata.addr == r_cmd.addr) begin
                                r_hit   <= 1'b1;
                                r_at    <= r_i;
                                r_state <= S_DECIDE;
                            end else if (r_i + One == r_n) begin
                                r_state <= S_DECIDE;
                            end else begin
                                r_i     <= r_i + One;
                                r_state <= S_SC_RD;
                            end
                        end
                    endcase
                end
                S_DECIDE: begin
                    if (r_cmd.op == OP_ADD) begin
                        if (r_hit) begin
                            r_status <= ST_DUP;
                            r_state  <= S_DONE;
                        end else if (r_n == CntMax) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_i     <= r_n;
                            r_state <= (r_n == r_at) ? S_INS : S_SH_RD;
                        end
                    end else begin
                        if (!r_hit) begin
                            r_status <= ST_ABSENT;
                            r_state  <= S_DONE;
                        end else begin
                            r_i <= r_at;
                            if (r_at + One == r_n) begin
                                r_n     <= r_n - One;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SH_RD;
                            end
                        end
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (r_cmd.op == OP_ADD) begin
                        r_i     <= r_i - One;
                        r_state <= (r_i - One == r_at) ? S_INS : S_SH_RD;
                    end else begin
                        r_i <= r_i + One;
                        if (r_i + Two == r_n) begin
                            r_n     <= r_n - One;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SH_RD;
                        end
                    end
                end
                S_INS: begin
                    r_n     <= r_n + One;
                    r_state <= S_DONE;
                end
                S_LK_RD: begin
                    r_state <= S_LK_CK;
                end
                S_LK_CK: begin
                    case (r_k)
                        2'd0:    r_pri <= r_rdata.addr;
                        2'd1:    r_sec <= r_rdata.addr;
                        default: r_ter <= r_rdata.addr;
                    endcase
                    r_i <= (r_i + One == r_n) ? '0 : r_i + One;
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_rv    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LK_RD;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/consistent_hash_replica_ring.sv
// Top level of the three-replica consistent-hash ring.
// Depends on chr_pkg, chr_front and chr_engine.
//
// One request is handled at a time by a sequencer that walks the table
// memory, visiting each entry in a read and a check state. A lookup scans for
// the primary, then reads three replicas; an add scans all members, then
// shifts entries up and inserts; a remove scans to the member, then shifts
// entries down. A lookup with under three members and an unknown mode go
// straight to the result. A two-entry request queue and a result register let
// both sides stall independently. No clearing pass after reset.
`default_nettype none
module consistent_hash_replica_ring
    import chr_pkg::*;
#(
    parameter int MAX_NODES = DefMaxNodes
)
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item
);

    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    chr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    chr_engine #(.MAX_NODES(MAX_NODES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

    a_rep_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.replicas_valid |->
            o_item.status == ST_OK && o_item.member_count >= CountOutW'(Replicas))
        else $error("replicas reported with bad status or too few members");

    a_rep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.replicas_valid |->
            o_item.primary_address == '0 && o_item.tertiary_address == '0)
        else $error("non-lookup result carries addresses");

    a_dup_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_item.status != ST_OK |=>
            !o_valid || o_item.member_count == $past(o_item.member_count)
            || o_item.status == ST_OK)
        else $error("member count changed on a failed update");

endmodule
`default_nettype wire
